@@ hdl/nva_pkg.sv @@
// shared types, constants and codes of the note voice allocator
`timescale 1ns / 1ps
`default_nettype none

package nva_pkg;

   // table size and register defaults
   localparam int MAX_CHANNELS_DEFAULT = 8;
   localparam logic [3:0] VOICE_COUNT_RESET = 4'd8;
   localparam logic [7:0] VOL_LIMIT = 8'd15;
   localparam int QUEUE_DEPTH = 2;

   // request operation codes
   typedef enum logic [1:0] {
      OP_NOTE_ON  = 2'd0,
      OP_NOTE_OFF = 2'd1,
      OP_ALL_OFF  = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   // command codes of a result beat
   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_START = 2'd1,
      CMD_END   = 2'd2,
      CMD_CUT   = 2'd3
   } cmd_type;

   // back end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK_RD,
      ST_LOOK_CMP,
      ST_CLAIM,
      ST_CUT,
      ST_EMIT
   } engine_state_type;

   // request beat payload
   typedef struct packed {
      logic [1:0] operation;
      logic [6:0] note_number;
      logic [7:0] volume;
      logic [7:0] source;
      logic [7:0] source_key;
      logic [2:0] start_channel;
      logic [7:0] instrument;
   } req_payload_type;

   // result beat payload
   typedef struct packed {
      logic [1:0] command;
      logic       found;
      logic [2:0] channel;
      logic [6:0] out_note;
      logic [7:0] out_instrument;
      logic       set_volume;
      logic [3:0] out_volume;
      logic       last;
   } rsp_payload_type;

   // classified job handed from the front end to the back end
   typedef struct packed {
      op_type     kind;
      logic [6:0] note;
      logic [7:0] source;
      logic [7:0] source_key;
      logic [2:0] start_channel;
      logic [7:0] instrument;
      logic       set_volume;
      logic [3:0] volume;
   } job_type;

   // owner fields of one channel entry
   typedef struct packed {
      logic [6:0] note;
      logic [7:0] source;
      logic [7:0] source_key;
   } entry_type;

   // final result with nothing found
   localparam rsp_payload_type RSP_NONE = '{
      command: CMD_NONE, found: 1'b0, channel: 3'd0, out_note: 7'd0,
      out_instrument: 8'd0, set_volume: 1'b0, out_volume: 4'd0, last: 1'b1
   };

endpackage

`default_nettype wire

@@ hdl/nva_if.sv @@
// request and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface nva_req_if;
   import nva_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface nva_rsp_if;
   import nva_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hdl/nva_front.sv @@
// front end: takes request beats and classifies them into jobs
`timescale 1ns / 1ps
`default_nettype none

module nva_front (
   nva_req_if.sink          req_port,
   output logic             push_valid,
   input  logic             push_ready,
   output nva_pkg::job_type push_data
);
   import nva_pkg::*;

   logic vol_ok;

   // handshake passes straight to the job queue
   assign push_valid = req_port.valid;
   assign req_port.ready = push_ready;

   // volume applies only at or below the limit
   assign vol_ok = (req_port.payload.volume <= VOL_LIMIT);

   // decode the request into a job
   always_comb begin
      push_data.kind = op_type'(req_port.payload.operation);
      push_data.note = req_port.payload.note_number;
      push_data.source = req_port.payload.source;
      push_data.source_key = req_port.payload.source_key;
      push_data.start_channel = req_port.payload.start_channel;
      push_data.instrument = req_port.payload.instrument;
      push_data.set_volume = vol_ok;
      push_data.volume = vol_ok ? req_port.payload.volume[3:0] : 4'd0;
   end

endmodule

`default_nettype wire

@@ hdl/nva_queue.sv @@
// short job queue between front end and back end
`timescale 1ns / 1ps
`default_nettype none

module nva_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  nva_pkg::job_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output nva_pkg::job_type pop_data
);
   import nva_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   job_type         slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign push_ready = (count_ff != CW'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ hdl/nva_engine.sv @@
// back end: channel table, scan sequencer and result register
`timescale 1ns / 1ps
`default_nettype none

module nva_engine #(
   parameter int MAX_CHANNELS = nva_pkg::MAX_CHANNELS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [3:0]       voice_count,
   input  logic             job_valid,
   output logic             job_pop,
   input  nva_pkg::job_type job_data,
   nva_rsp_if.source        rsp_port
);
   import nva_pkg::*;

   localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int LW = ($clog2(MAX_CHANNELS + 1) > 4) ? $clog2(MAX_CHANNELS + 1) : 4;

   engine_state_type       state_ff, state_in;
   job_type                job_ff, job_in;
   logic [LW-1:0]          c_ff, c_in;
   rsp_payload_type        res_ff, res_in;
   logic                   held_ff, held_in;
   logic [2:0]             held_ch_ff, held_ch_in;
   logic [MAX_CHANNELS-1:0] active_ff, active_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   entry_type              entry_mem [MAX_CHANNELS];
   entry_type              rd_data_ff;
   entry_type              wr_entry;
   logic                   mem_we;

   logic [LW-1:0]          count_wide;
   logic [LW-1:0]          lim;
   logic [IW-1:0]          c_idx;
   logic                   in_range;
   logic                   cur_active;
   logic                   hit;
   logic                   claim_go;
   logic                   out_ready;

   // scan limit is the smaller of register and table size
   assign count_wide = LW'(voice_count);
   assign lim = (count_wide > LW'(MAX_CHANNELS)) ? LW'(MAX_CHANNELS) : count_wide;

   // scan position and per-entry tests
   assign c_idx = c_ff[IW-1:0];
   assign in_range = (c_ff < lim);
   assign cur_active = active_ff[c_idx];
   assign hit = cur_active && (rd_data_ff.note == job_ff.note)
                && (rd_data_ff.source == job_ff.source)
                && (rd_data_ff.source_key == job_ff.source_key);
   assign claim_go = in_range && !cur_active;
   assign out_ready = !rsp_valid_ff || rsp_port.ready;
   assign job_pop = (state_ff == ST_IDLE) && job_valid;

   assign wr_entry.note = job_ff.note;
   assign wr_entry.source = job_ff.source;
   assign wr_entry.source_key = job_ff.source_key;

   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.payload = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               case (job_data.kind)
                  OP_NONE:    state_in = ST_EMIT;
                  OP_ALL_OFF: state_in = ST_CUT;
                  default:    state_in = ST_LOOK_RD;
               endcase
            end
         end
         ST_LOOK_RD: begin
            if (!in_range) begin
               state_in = (job_ff.kind == OP_NOTE_ON) ? ST_CLAIM : ST_EMIT;
            end else begin
               state_in = ST_LOOK_CMP;
            end
         end
         ST_LOOK_CMP: begin
            state_in = hit ? ST_EMIT : ST_LOOK_RD;
         end
         ST_CLAIM: begin
            if (!in_range || !cur_active) begin
               state_in = ST_EMIT;
            end
         end
         ST_CUT: begin
            if (!in_range || (cur_active && held_ff)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_ready) begin
               state_in = res_ff.last ? ST_IDLE : ST_CUT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and table updates
   always_comb begin
      job_in = job_ff;
      c_in = c_ff;
      res_in = res_ff;
      held_in = held_ff;
      held_ch_in = held_ch_ff;
      active_in = active_ff;
      mem_we = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      rsp_data_in = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_in = job_data;
               c_in = '0;
               held_in = 1'b0;
               res_in = RSP_NONE;
            end
         end
         ST_LOOK_RD: begin
            // entry read is issued by the memory block at c_idx
            if (!in_range && (job_ff.kind == OP_NOTE_ON)) begin
               c_in = LW'(job_ff.start_channel);
            end
         end
         ST_LOOK_CMP: begin
            if (hit) begin
               res_in = RSP_NONE;
               res_in.found = 1'b1;
               res_in.channel = c_ff[2:0];
               if (job_ff.kind == OP_NOTE_OFF) begin
                  res_in.command = CMD_END;
                  active_in[c_idx] = 1'b0;
               end
            end else begin
               c_in = c_ff + 1'b1;
            end
         end
         ST_CLAIM: begin
            if (!in_range) begin
               res_in = RSP_NONE;
            end else if (!cur_active) begin
               active_in[c_idx] = 1'b1;
               mem_we = 1'b1;
               res_in = RSP_NONE;
               res_in.command = CMD_START;
               res_in.found = 1'b1;
               res_in.channel = c_ff[2:0];
               res_in.out_note = job_ff.note;
               res_in.out_instrument = job_ff.instrument;
               res_in.set_volume = job_ff.set_volume;
               res_in.out_volume = job_ff.volume;
            end else begin
               c_in = c_ff + 1'b1;
            end
         end
         ST_CUT: begin
            // one cut is held back so the final one can carry last
            if (!in_range) begin
               res_in = RSP_NONE;
               if (held_ff) begin
                  res_in.command = CMD_CUT;
                  res_in.found = 1'b1;
                  res_in.channel = held_ch_ff;
               end
            end else begin
               if (cur_active) begin
                  active_in[c_idx] = 1'b0;
                  held_in = 1'b1;
                  held_ch_in = c_ff[2:0];
                  if (held_ff) begin
                     res_in = RSP_NONE;
                     res_in.command = CMD_CUT;
                     res_in.found = 1'b1;
                     res_in.channel = held_ch_ff;
                     res_in.last = 1'b0;
                  end
               end
               c_in = c_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         active_ff <= '0;
         rsp_valid_ff <= 1'b0;
         held_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         active_ff <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         held_ff <= held_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      job_ff <= job_in;
      c_ff <= c_in;
      res_ff <= res_in;
      held_ch_ff <= held_ch_in;
      rsp_data_ff <= rsp_data_in;
   end

   // entry owner memory, one port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[c_idx] <= wr_entry;
      end
      rd_data_ff <= entry_mem[c_idx];
   end

   // a start beat is always a final, found result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.command == CMD_START))
      |-> (rsp_data_ff.found && rsp_data_ff.last))
      else $error("start beat without found or last");

   // a claimed channel is active right after the claim
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_CLAIM) && claim_go) |=> active_ff[$past(c_idx)])
      else $error("claimed channel not marked active");

   // entry compare only ever looks below the scan limit
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK_CMP) |-> (c_ff < lim))
      else $error("entry compare beyond scan limit");

   // a beat without a channel carries no channel number or command
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.found)
      |-> ((rsp_data_ff.channel == 3'd0) && (rsp_data_ff.command == CMD_NONE)))
      else $error("not-found beat carries a channel or command");

   // jobs leave the queue only while the sequencer is idle
   assert property (@(posedge clock) disable iff (reset)
      job_pop |=> (state_ff != ST_IDLE))
      else $error("job popped without starting work");

endmodule

`default_nettype wire

@@ hdl/note_voice_allocator_top.sv @@
// top level of the note voice allocator
//
//   channel   dir  beat contents
//   req_port  in   operation, note, volume, owner, start channel, instrument
//   rsp_port  out  command, found, channel, note, instrument, volume, last
//   csr_*     in   voice count write, 4 bits, no read-back
//
// the back end walks the channel table: a lookup reads each entry from the
// single-port owner memory and then compares it, a claim tests the active
// marks from the start channel upward, and all-off tests every entry below
// the limit; each result beat passes through the emit state, and a beat
// waits there for rsp ready.
// reset clears the active marks at once; there is no clearing pass.
// the request side keeps accepting into a two-job queue while a result
// beat waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module note_voice_allocator_top #(
   parameter int MAX_CHANNELS = nva_pkg::MAX_CHANNELS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [3:0] csr_write_data,
   nva_req_if.sink    req_port,
   nva_rsp_if.source  rsp_port
);
   import nva_pkg::*;

   logic [3:0] voice_count_ff, voice_count_in;
   logic       push_valid, push_ready;
   job_type    push_data;
   logic       job_valid, job_pop;
   job_type    job_data;

   // voice count register
   assign voice_count_in = csr_write_enable ? csr_write_data : voice_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         voice_count_ff <= VOICE_COUNT_RESET;
      end else begin
         voice_count_ff <= voice_count_in;
      end
   end

   nva_front u_front (
      .req_port   (req_port),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   nva_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (job_valid),
      .pop_ready  (job_pop),
      .pop_data   (job_data)
   );

   nva_engine #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .voice_count (voice_count_ff),
      .job_valid   (job_valid),
      .job_pop     (job_pop),
      .job_data    (job_data),
      .rsp_port    (rsp_port)
   );

endmodule

`default_nettype wire

@@ bench/tb_note_voice_allocator_top.sv @@
// self-checking testbench for the note voice allocator top level
`timescale 1ns / 1ps

module tb_note_voice_allocator_top;
   import nva_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int STUCK_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES = 30;
   localparam int PHASE_ITEMS = 50;

   // channel table predictor and store of expected result beats
   class voice_table_predictor;
      logic [3:0] voice_count;
      bit         held[MAX_CHANNELS_DEFAULT];
      logic [6:0] held_note[MAX_CHANNELS_DEFAULT];
      logic [7:0] held_source[MAX_CHANNELS_DEFAULT];
      logic [7:0] held_source_key[MAX_CHANNELS_DEFAULT];
      rsp_payload_type expected_beats[$];
      int failures;

      function new();
         voice_count = VOICE_COUNT_RESET;
         foreach (held[c]) begin
            held[c] = 1'b0;
         end
         failures = 0;
      endfunction

      function int scan_limit();
         return (voice_count < MAX_CHANNELS_DEFAULT) ? int'(voice_count)
                                                      : MAX_CHANNELS_DEFAULT;
      endfunction

      function int find_owner(req_payload_type r);
         for (int c = 0; c < scan_limit(); c++) begin
            if (held[c] && held_note[c] == r.note_number && held_source[c] == r.source &&
                held_source_key[c] == r.source_key)
               return c;
         end
         return -1;
      endfunction

      // pick the owner of a random held channel within the limit
      function bit pick_held(inout logic [6:0] note, inout logic [7:0] src,
                             inout logic [7:0] sid);
         int busy[$];
         int c;
         for (int i = 0; i < scan_limit(); i++) begin
            if (held[i]) busy.push_back(i);
         end
         if (busy.size() == 0) return 1'b0;
         c = busy[$urandom_range(busy.size() - 1)];
         note = held_note[c];
         src = held_source[c];
         sid = held_source_key[c];
         return 1'b1;
      endfunction

      // work out the result beats of one accepted request beat
      function void note_request(req_payload_type r);
         rsp_payload_type b;
         rsp_payload_type prev;
         bit have_prev;
         int hit;
         int lim;
         lim = scan_limit();
         b = RSP_NONE;
         have_prev = 1'b0;
         case (op_type'(r.operation))
            OP_NOTE_ON: begin
               hit = find_owner(r);
               if (hit >= 0) begin
                  b.found = 1'b1;
                  b.channel = hit[2:0];
               end else begin
                  for (int c = int'(r.start_channel); c < lim; c++) begin
                     if (!held[c]) begin
                        held[c] = 1'b1;
                        held_note[c] = r.note_number;
                        held_source[c] = r.source;
                        held_source_key[c] = r.source_key;
                        b.command = CMD_START;
                        b.found = 1'b1;
                        b.channel = c[2:0];
                        b.out_note = r.note_number;
                        b.out_instrument = r.instrument;
                        if (r.volume <= VOL_LIMIT) begin
                           b.set_volume = 1'b1;
                           b.out_volume = r.volume[3:0];
                        end
                        break;
                     end
                  end
               end
               expected_beats.push_back(b);
            end
            OP_NOTE_OFF: begin
               hit = find_owner(r);
               if (hit >= 0) begin
                  held[hit] = 1'b0;
                  b.command = CMD_END;
                  b.found = 1'b1;
                  b.channel = hit[2:0];
               end
               expected_beats.push_back(b);
            end
            OP_ALL_OFF: begin
               // one cut per held channel, last mark on the final one
               for (int c = 0; c < lim; c++) begin
                  if (held[c]) begin
                     held[c] = 1'b0;
                     if (have_prev) expected_beats.push_back(prev);
                     prev = RSP_NONE;
                     prev.command = CMD_CUT;
                     prev.found = 1'b1;
                     prev.channel = c[2:0];
                     prev.last = 1'b0;
                     have_prev = 1'b1;
                  end
               end
               if (have_prev) begin
                  prev.last = 1'b1;
                  expected_beats.push_back(prev);
               end else begin
                  expected_beats.push_back(b);
               end
            end
            default: expected_beats.push_back(b);
         endcase
      endfunction

      // compare an accepted result beat with the oldest expectation
      function void check_beat(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_beats.size() == 0) begin
            $error("unexpected result beat: command %0d channel %0d", got.command,
                   got.channel);
            failures++;
            return;
         end
         want = expected_beats.pop_front();
         if (got.command !== want.command) begin
            $error("command: expected %0d, actual %0d", want.command, got.command);
            failures++;
         end
         if (got.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            failures++;
         end
         if (got.channel !== want.channel) begin
            $error("channel: expected %0d, actual %0d", want.channel, got.channel);
            failures++;
         end
         if (got.out_note !== want.out_note) begin
            $error("out_note: expected %0d, actual %0d", want.out_note, got.out_note);
            failures++;
         end
         if (got.out_instrument !== want.out_instrument) begin
            $error("out_instrument: expected %0d, actual %0d", want.out_instrument,
                   got.out_instrument);
            failures++;
         end
         if (got.set_volume !== want.set_volume) begin
            $error("set_volume: expected %0d, actual %0d", want.set_volume, got.set_volume);
            failures++;
         end
         if (got.out_volume !== want.out_volume) begin
            $error("out_volume: expected %0d, actual %0d", want.out_volume, got.out_volume);
            failures++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            failures++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [3:0] csr_write_data;

   nva_req_if req_bus ();
   nva_rsp_if rsp_bus ();

   voice_table_predictor voices = new();

   int req_idle_pct;
   int rsp_idle_pct;
   int hold_asks;
   int holds_done = 0;
   int hold_left = 0;
   int stuck_cycles = 0;

   note_voice_allocator_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_port         (req_bus),
      .rsp_port         (rsp_bus)
   );

   // clock, 10 ns period
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // result side: check accepted beats, then drive ready
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         voices.check_beat(rsp_bus.payload);
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_asks != holds_done) begin
         // long hold-off so the request side backs up
         rsp_bus.ready <= 1'b0;
         holds_done <= holds_done + 1;
         hold_left <= HOLD_CYCLES;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // watchdog on cycles with no beat moving
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // offer one request beat after an optional gap, return once it is taken
   task automatic send_request(input req_payload_type item);
      if ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < req_idle_pct) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.payload <= item;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      voices.note_request(item);
   endtask

   task automatic send_note(input op_type op, input int note, input int vol, input int src,
                            input int sid, input int start, input int inst);
      req_payload_type r;
      r.operation = op;
      r.note_number = note[6:0];
      r.volume = vol[7:0];
      r.source = src[7:0];
      r.source_key = sid[7:0];
      r.start_channel = start[2:0];
      r.instrument = inst[7:0];
      send_request(r);
   endtask

   // register write once every expected beat has come back
   task automatic write_voice_count(input logic [3:0] value);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (voices.expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      voices.voice_count = value;
   endtask

   function automatic logic [7:0] owner_id();
      return ($urandom_range(3) != 0) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
   endfunction

   // mostly well-formed note traffic over a small set of owners
   function automatic req_payload_type random_request();
      req_payload_type r;
      int roll;
      r.operation = OP_NOTE_ON;
      r.note_number = 7'($urandom_range(127));
      r.volume = $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
      r.source = owner_id();
      r.source_key = owner_id();
      r.start_channel = $urandom_range(3) ? 3'($urandom_range(3)) : 3'($urandom_range(7));
      r.instrument = 8'($urandom_range(255));
      roll = $urandom_range(99);
      if (roll < 40) begin
         r.operation = OP_NOTE_ON;
      end else if (roll < 55) begin
         // repeat of a held note
         r.operation = OP_NOTE_ON;
         void'(voices.pick_held(r.note_number, r.source, r.source_key));
      end else if (roll < 85) begin
         r.operation = OP_NOTE_OFF;
         void'(voices.pick_held(r.note_number, r.source, r.source_key));
      end else if (roll < 93) begin
         r.operation = OP_ALL_OFF;
      end else if (roll < 97) begin
         r.operation = OP_NOTE_OFF;
      end else begin
         r.operation = OP_NONE;
      end
      return r;
   endfunction

   // main sequence
   initial begin
      logic [3:0] phase_counts[6];
      phase_counts = '{4'd8, 4'd3, 4'd15, 4'd1, 4'd6, 4'd8};
      hold_asks = 0;
      req_idle_pct = 27;
      rsp_idle_pct = 47;
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data <= 4'd0;
      req_bus.valid <= 1'b0;
      req_bus.payload <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, ignored operation, unmatched note off
      send_note(OP_ALL_OFF, 5, 3, 1, 1, 2, 9);
      send_note(OP_NONE, 127, 255, 255, 255, 7, 255);
      send_note(OP_NOTE_OFF, 60, 0, 1, 1, 0, 0);
      // claim, existing owner, top channel, no free channel above start
      send_note(OP_NOTE_ON, 0, 0, 0, 0, 0, 0);
      send_note(OP_NOTE_ON, 0, 7, 0, 0, 3, 44);
      send_note(OP_NOTE_ON, 127, 15, 255, 255, 7, 255);
      send_note(OP_NOTE_ON, 64, 16, 1, 2, 7, 1);
      send_note(OP_NOTE_ON, 65, 255, 1, 2, 3, 2);
      for (int i = 0; i < 5; i++) begin
         send_note(OP_NOTE_ON, 70 + i, i, 2, i, 0, 10 + i);
      end
      // full table
      send_note(OP_NOTE_ON, 90, 8, 3, 3, 0, 5);
      send_note(OP_NOTE_OFF, 127, 9, 255, 255, 4, 200);
      send_note(OP_NOTE_OFF, 127, 9, 255, 255, 4, 200);
      send_note(OP_ALL_OFF, 0, 0, 0, 0, 0, 0);
      // zero channels: nothing is searched
      write_voice_count(4'd0);
      send_note(OP_NOTE_ON, 10, 1, 1, 1, 0, 1);
      send_note(OP_ALL_OFF, 0, 0, 0, 0, 0, 0);
      // count above the table size is clamped
      write_voice_count(4'd15);
      send_note(OP_NOTE_ON, 11, 2, 1, 1, 7, 3);
      // one channel: start channel at the limit, then channels beyond it stay held
      write_voice_count(4'd1);
      send_note(OP_NOTE_ON, 12, 3, 1, 1, 1, 4);
      send_note(OP_NOTE_ON, 12, 3, 1, 1, 0, 4);
      send_note(OP_ALL_OFF, 0, 0, 0, 0, 0, 0);
      write_voice_count(4'd8);
      send_note(OP_ALL_OFF, 0, 0, 0, 0, 0, 0);

      // random phases over several channel counts and idling mixes
      for (int phase = 0; phase < 6; phase++) begin
         if (phase < 2) begin
            req_idle_pct = 27;
            rsp_idle_pct = 47;
         end else if (phase < 4) begin
            req_idle_pct = 47;
            rsp_idle_pct = 27;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         write_voice_count(phase_counts[phase]);
         if (phase == 1) hold_asks = hold_asks + 1;
         repeat (PHASE_ITEMS) send_request(random_request());
      end

      // drain and finish
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (voices.expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (voices.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/nva_pkg.sv
hdl/nva_if.sv
hdl/nva_front.sv
hdl/nva_queue.sv
hdl/nva_engine.sv
hdl/note_voice_allocator_top.sv
bench/tb_note_voice_allocator_top.sv
